### rtl/core/stq_pkg.sv
package stq_pkg;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [19:0] USEC_MAX     = 20'd999999;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;

    localparam logic [2:0] KIND_SET_DONE    = 3'd0;
    localparam logic [2:0] KIND_CANCEL_DONE = 3'd1;
    localparam logic [2:0] KIND_EXPIRED     = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT     = 3'd3;
    localparam logic [2:0] KIND_EMPTY       = 3'd4;
    localparam logic [2:0] KIND_FULL        = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [31:0] exp_sec;
        logic [19:0] exp_usec;
        logic [31:0] per_sec;
        logic [19:0] per_usec;
    } t_tm;

    typedef struct packed {
        logic rem;
        logic pop;
        logic ins;
        t_tm  new_tm;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_INS,
        ST_CHK,
        ST_REL
    } t_state;

    function automatic logic [19:0] sat_usec(input logic [19:0] v);
        return (v > USEC_MAX) ? USEC_MAX : v;
    endfunction

    function automatic logic tm_less(input logic [31:0] as, input logic [19:0] au,
                                     input logic [31:0] bs, input logic [19:0] bu);
        return (as < bs) || ((as == bs) && (au < bu));
    endfunction

    function automatic logic [51:0] tm_add(input logic [31:0] as, input logic [19:0] au,
                                           input logic [31:0] bs, input logic [19:0] bu);
        logic [20:0] u;
        logic [31:0] s;
        u = {1'b0, au} + {1'b0, bu};
        s = as + bs;
        if (u >= {1'b0, USEC_PER_SEC}) begin
            u = u - {1'b0, USEC_PER_SEC};
            s = s + 32'd1;
        end
        return {s, u[19:0]};
    endfunction

endpackage

### rtl/core/stq_cell.sv
module stq_cell #(
    parameter int CLIENT_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  stq_pkg::t_cmd          i_cmd,
    input  logic [CLIENT_BITS-1:0] i_client,
    input  logic [CLIENT_BITS-1:0] i_new_owner,
    input  stq_pkg::t_tm           i_left_tm,
    input  logic [CLIENT_BITS-1:0] i_left_owner,
    input  logic                   i_left_keep,
    input  stq_pkg::t_tm           i_right_tm,
    input  logic [CLIENT_BITS-1:0] i_right_owner,
    input  logic                   i_hit_in,
    output stq_pkg::t_tm           o_tm,
    output logic [CLIENT_BITS-1:0] o_owner,
    output logic                   o_keep,
    output logic                   o_hit_out
);
    import stq_pkg::*;

    t_tm                   r_tm, n_tm;
    logic [CLIENT_BITS-1:0] r_owner, n_owner;
    logic                  match, keep;

    assign match     = r_tm.valid && (r_owner == i_client);
    assign o_hit_out = i_hit_in || match;
    assign keep      = r_tm.valid &&
                       !tm_less(i_cmd.new_tm.exp_sec, i_cmd.new_tm.exp_usec,
                                r_tm.exp_sec, r_tm.exp_usec);
    assign o_keep    = keep;
    assign o_tm      = r_tm;
    assign o_owner   = r_owner;

    always_comb begin
        n_tm    = r_tm;
        n_owner = r_owner;
        if (i_cmd.pop || (i_cmd.rem && o_hit_out)) begin
            n_tm    = i_right_tm;
            n_owner = i_right_owner;
        end else if (i_cmd.ins && !keep) begin
            if (i_left_keep) begin
                n_tm       = i_cmd.new_tm;
                n_tm.valid = 1'b1;
                n_owner    = i_new_owner;
            end else begin
                n_tm    = i_left_tm;
                n_owner = i_left_owner;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_owner <= n_owner;
        if (!i_rst_n) begin
            r_tm <= '0;
        end else begin
            r_tm <= n_tm;
        end
    end

endmodule

### rtl/core/sorted_timer_queue.sv
// Set: result strobe 2 cycles after the accepting edge; cancel: 1 cycle.
// Get: 1 cycle per expired one-shot, 2 per expired periodic timer (pop, then
// reinsert through the cell row), plus 1 cycle for the closing result.
// busy stays high until the last result is registered; a new start may be
// taken in the cycle that result is shown. The receiver cannot stall.
// Synchronous active-low reset empties the queue and clears the strobe.
module sorted_timer_queue #(
    parameter int NUM_TIMERS  = 16,
    parameter int CLIENT_BITS = 8,
    parameter int MAX_EXPIRE  = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_client_id,
    input  logic [31:0] i_value_sec,
    input  logic [19:0] i_value_usec,
    input  logic [31:0] i_period_sec,
    input  logic [19:0] i_period_usec,
    input  logic        i_relative_flag,
    input  logic [31:0] i_now_sec,
    input  logic [19:0] i_now_usec,
    output logic        o_result_valid,
    output logic [2:0]  o_result_kind,
    output logic [7:0]  o_result_client,
    output logic [31:0] o_time_sec,
    output logic [19:0] o_time_usec,
    output logic        o_any_pending,
    output logic        o_last_of_run
);
    import stq_pkg::*;

    localparam int CW = $clog2(NUM_TIMERS + 1);

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [5:0]             r_k, n_k;
    logic [1:0]             r_op;
    logic [CLIENT_BITS-1:0] r_client;
    logic [CLIENT_BITS-1:0] r_owner, n_owner;
    logic [31:0]            r_exp_sec, n_exp_sec, r_per_sec, n_per_sec, r_now_sec;
    logic [19:0]            r_exp_usec, n_exp_usec, r_per_usec, n_per_usec, r_now_usec;

    logic                   r_valid, n_valid;
    logic [2:0]             r_kind, n_kind;
    logic [7:0]             r_rclient, n_rclient;
    logic [31:0]            r_tsec, n_tsec;
    logic [19:0]            r_tusec, n_tusec;
    logic                   r_pend, n_pend, r_last, n_last;

    t_cmd                   cmd;
    t_tm                    tm    [NUM_TIMERS];
    logic [CLIENT_BITS-1:0] own   [NUM_TIMERS];
    logic                   keep  [NUM_TIMERS];
    logic                   hit   [NUM_TIMERS];
    t_tm                    tm_none;
    logic [15:0]            cid_ext, own_ext, rcl_ext;
    logic [CLIENT_BITS-1:0] in_client;
    logic [19:0]            s_vu, s_pu, s_nu;
    logic [51:0]            rel_sum, rel_head;
    logic                   found, full, periodic, head_later;
    logic [31:0]            to_sec;
    logic [19:0]            to_usec;

    assign tm_none   = '0;
    assign cid_ext   = 16'(i_client_id);
    assign in_client = cid_ext[CLIENT_BITS-1:0];
    assign own_ext   = 16'(own[0]);
    assign rcl_ext   = 16'(r_client);
    assign s_vu      = sat_usec(i_value_usec);
    assign s_pu      = sat_usec(i_period_usec);
    assign s_nu      = sat_usec(i_now_usec);
    assign rel_sum   = tm_add(i_now_sec, s_nu, i_value_sec, s_vu);
    assign rel_head  = tm_add(tm[0].per_sec, tm[0].per_usec, tm[0].exp_sec, tm[0].exp_usec);
    assign found     = hit[NUM_TIMERS-1];
    assign full      = (r_cnt == CW'(NUM_TIMERS));
    assign periodic  = (tm[0].per_sec != 32'd0) || (tm[0].per_usec != 20'd0);
    assign head_later = tm_less(r_now_sec, r_now_usec, tm[0].exp_sec, tm[0].exp_usec);

    always_comb begin
        to_sec = tm[0].exp_sec - r_now_sec;
        if (tm[0].exp_usec >= r_now_usec) begin
            to_usec = tm[0].exp_usec - r_now_usec;
        end else begin
            to_usec = tm[0].exp_usec + USEC_PER_SEC - r_now_usec;
            to_sec  = to_sec - 32'd1;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
            stq_cell #(.CLIENT_BITS(CLIENT_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_client     (r_client),
                .i_new_owner  (r_owner),
                .i_left_tm    ((gi == 0) ? tm_none : tm[(gi == 0) ? 0 : gi-1]),
                .i_left_owner (own[(gi == 0) ? 0 : gi-1]),
                .i_left_keep  ((gi == 0) ? 1'b1 : keep[(gi == 0) ? 0 : gi-1]),
                .i_right_tm   ((gi == NUM_TIMERS-1) ? tm_none
                               : tm[(gi == NUM_TIMERS-1) ? gi : gi+1]),
                .i_right_owner(own[(gi == NUM_TIMERS-1) ? gi : gi+1]),
                .i_hit_in     ((gi == 0) ? 1'b0 : hit[(gi == 0) ? 0 : gi-1]),
                .o_tm         (tm[gi]),
                .o_owner      (own[gi]),
                .o_keep       (keep[gi]),
                .o_hit_out    (hit[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_operation == OP_SET || i_operation == OP_CANCEL) begin
                        n_state = ST_REM;
                    end else if (i_operation == OP_GET) begin
                        n_state = ST_CHK;
                    end
                end
            end
            ST_REM: n_state = (r_op == OP_CANCEL) ? ST_IDLE : ST_INS;
            ST_INS: n_state = ST_IDLE;
            ST_CHK: begin
                if (r_cnt == '0 || head_later || r_k >= 6'(MAX_EXPIRE)) begin
                    n_state = ST_IDLE;
                end else if (periodic) begin
                    n_state = ST_REL;
                end
            end
            ST_REL: n_state = ST_CHK;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.new_tm     = '{1'b1, r_exp_sec, r_exp_usec, r_per_sec, r_per_usec};
        n_cnt          = r_cnt;
        n_k            = r_k;
        n_owner        = r_owner;
        n_exp_sec      = r_exp_sec;
        n_exp_usec     = r_exp_usec;
        n_per_sec      = r_per_sec;
        n_per_usec     = r_per_usec;
        n_valid        = 1'b0;
        n_kind         = r_kind;
        n_rclient      = rcl_ext[7:0];
        n_tsec         = 32'd0;
        n_tusec        = 20'd0;
        n_pend         = r_cnt != '0;
        n_last         = 1'b1;
        case (r_state)
            ST_IDLE: begin
                n_k        = '0;
                n_owner    = in_client;
                n_exp_sec  = i_relative_flag ? rel_sum[51:20] : i_value_sec;
                n_exp_usec = i_relative_flag ? rel_sum[19:0] : s_vu;
                n_per_sec  = i_period_sec;
                n_per_usec = s_pu;
            end
            ST_REM: begin
                cmd.rem = 1'b1;
                if (found) begin
                    n_cnt = r_cnt - CW'(1);
                end
                if (r_op == OP_CANCEL) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_CANCEL_DONE;
                    n_pend  = n_cnt != '0;
                end
            end
            ST_INS: begin
                n_valid = 1'b1;
                if (full) begin
                    n_kind = KIND_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    n_cnt   = r_cnt + CW'(1);
                    n_kind  = KIND_SET_DONE;
                    n_pend  = 1'b1;
                end
            end
            ST_CHK: begin
                n_valid = 1'b1;
                if (r_cnt == '0) begin
                    n_kind = KIND_EMPTY;
                end else if (head_later) begin
                    n_kind  = KIND_TIMEOUT;
                    n_tsec  = to_sec;
                    n_tusec = to_usec;
                end else if (r_k >= 6'(MAX_EXPIRE)) begin
                    n_kind = KIND_TIMEOUT;
                end else begin
                    cmd.pop    = 1'b1;
                    n_cnt      = r_cnt - CW'(1);
                    n_k        = r_k + 6'd1;
                    n_kind     = KIND_EXPIRED;
                    n_rclient  = own_ext[7:0];
                    n_pend     = (r_cnt > CW'(1)) || periodic;
                    n_last     = 1'b0;
                    n_owner    = own[0];
                    n_exp_sec  = rel_head[51:20];
                    n_exp_usec = rel_head[19:0];
                    n_per_sec  = tm[0].per_sec;
                    n_per_usec = tm[0].per_usec;
                end
            end
            ST_REL: begin
                cmd.ins = 1'b1;
                n_cnt   = r_cnt + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_owner    <= n_owner;
        r_exp_sec  <= n_exp_sec;
        r_exp_usec <= n_exp_usec;
        r_per_sec  <= n_per_sec;
        r_per_usec <= n_per_usec;
        r_kind     <= n_kind;
        r_rclient  <= n_rclient;
        r_tsec     <= n_tsec;
        r_tusec    <= n_tusec;
        r_pend     <= n_pend;
        r_last     <= n_last;
        r_k        <= n_k;
        if (r_state == ST_IDLE && start) begin
            r_op       <= i_operation;
            r_client   <= in_client;
            r_now_sec  <= i_now_sec;
            r_now_usec <= s_nu;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign busy            = r_state != ST_IDLE;
    assign o_result_valid  = r_valid;
    assign o_result_kind   = r_kind;
    assign o_result_client = r_rclient;
    assign o_time_sec      = r_tsec;
    assign o_time_usec     = r_tusec;
    assign o_any_pending   = r_pend;
    assign o_last_of_run   = r_last;

endmodule

### rtl/core/stq_checker.sv
module stq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_result_valid,
    input logic [2:0] o_result_kind,
    input logic       o_last_of_run
);
    import stq_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_operation != 2'd3 |=> busy)
        else $error("accepted beat did not raise busy");

    a_expired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result_kind == KIND_EXPIRED |-> !o_last_of_run)
        else $error("expired beat marked last");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result_kind != KIND_EXPIRED |-> o_last_of_run && !busy)
        else $error("closing beat not last or block still busy");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_result_kind <= KIND_FULL)
        else $error("bad result kind");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_operation   (i_operation),
    .o_result_valid(o_result_valid),
    .o_result_kind (o_result_kind),
    .o_last_of_run (o_last_of_run)
);

### tb/sv/tb_sorted_timer_queue.sv
module tb_sorted_timer_queue;
    import stq_pkg::*;

    localparam int SLOTS      = 16;
    localparam int EXPIRE_CAP = 63;
    localparam int WATCHDOG   = 4000;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  client;
        logic [31:0] val_sec;
        logic [19:0] val_usec;
        logic [31:0] per_sec;
        logic [19:0] per_usec;
        logic        rel;
        logic [31:0] now_sec;
        logic [19:0] now_usec;
    } timer_req_t;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  client;
        logic [31:0] t_sec;
        logic [19:0] t_usec;
        logic        pending;
        logic        last;
    } timer_evt_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [7:0]  i_client_id;
    logic [31:0] i_value_sec;
    logic [19:0] i_value_usec;
    logic [31:0] i_period_sec;
    logic [19:0] i_period_usec;
    logic        i_relative_flag;
    logic [31:0] i_now_sec;
    logic [19:0] i_now_usec;
    logic        o_result_valid;
    logic [2:0]  o_result_kind;
    logic [7:0]  o_result_client;
    logic [31:0] o_time_sec;
    logic [19:0] o_time_usec;
    logic        o_any_pending;
    logic        o_last_of_run;

    sorted_timer_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_client_id(i_client_id),
        .i_value_sec(i_value_sec), .i_value_usec(i_value_usec),
        .i_period_sec(i_period_sec), .i_period_usec(i_period_usec),
        .i_relative_flag(i_relative_flag), .i_now_sec(i_now_sec),
        .i_now_usec(i_now_usec), .o_result_valid(o_result_valid),
        .o_result_kind(o_result_kind), .o_result_client(o_result_client),
        .o_time_sec(o_time_sec), .o_time_usec(o_time_usec),
        .o_any_pending(o_any_pending), .o_last_of_run(o_last_of_run)
    );

    timer_req_t req_q[$];
    timer_evt_t expected_evts[$];
    timer_req_t cur_req;
    int         mismatches;
    int         idle_cycles;
    int         gap_left;
    int         burst_left;

    logic [31:0] q_exp_sec[SLOTS];
    logic [19:0] q_exp_usec[SLOTS];
    logic [31:0] q_per_sec[SLOTS];
    logic [19:0] q_per_usec[SLOTS];
    logic [7:0]  q_owner[SLOTS];
    int          q_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [19:0] clamp_usec(logic [19:0] v);
        return (v > 20'd999999) ? 20'd999999 : v;
    endfunction

    function automatic logic earlier(logic [31:0] as, logic [19:0] au,
                                     logic [31:0] bs, logic [19:0] bu);
        return (as < bs) || (as == bs && au < bu);
    endfunction

    function automatic logic [51:0] time_sum(logic [31:0] as, logic [19:0] au,
                                             logic [31:0] bs, logic [19:0] bu);
        logic [20:0] u;
        logic [31:0] s;
        u = {1'b0, au} + {1'b0, bu};
        s = as + bs;
        if (u >= 21'd1000000) begin
            u = u - 21'd1000000;
            s = s + 32'd1;
        end
        return {s, u[19:0]};
    endfunction

    task automatic drop_slot(int p);
        for (int i = p; i + 1 < q_count; i++) begin
            q_exp_sec[i]  = q_exp_sec[i+1];
            q_exp_usec[i] = q_exp_usec[i+1];
            q_per_sec[i]  = q_per_sec[i+1];
            q_per_usec[i] = q_per_usec[i+1];
            q_owner[i]    = q_owner[i+1];
        end
        if (q_count > 0) q_count--;
    endtask

    task automatic drop_client(logic [7:0] c);
        for (int i = 0; i < q_count; i++) begin
            if (q_owner[i] == c) begin
                drop_slot(i);
                return;
            end
        end
    endtask

    task automatic place_timer(logic [31:0] es, logic [19:0] eu, logic [31:0] ps,
                               logic [19:0] pu, logic [7:0] c);
        int p;
        p = 0;
        while (p < q_count && !earlier(es, eu, q_exp_sec[p], q_exp_usec[p])) p++;
        for (int i = q_count; i > p; i--) begin
            q_exp_sec[i]  = q_exp_sec[i-1];
            q_exp_usec[i] = q_exp_usec[i-1];
            q_per_sec[i]  = q_per_sec[i-1];
            q_per_usec[i] = q_per_usec[i-1];
            q_owner[i]    = q_owner[i-1];
        end
        q_exp_sec[p] = es;
        q_exp_usec[p] = eu;
        q_per_sec[p] = ps;
        q_per_usec[p] = pu;
        q_owner[p] = c;
        q_count++;
    endtask

    task automatic post_evt(logic [2:0] kind, logic [7:0] c, logic [31:0] ts,
                            logic [19:0] tu, logic last);
        timer_evt_t e;
        e.kind = kind;
        e.client = c;
        e.t_sec = ts;
        e.t_usec = tu;
        e.pending = (q_count > 0);
        e.last = last;
        expected_evts.push_back(e);
    endtask

    task automatic predict_timer_req(timer_req_t r);
        logic [19:0] vu, pu, nu, hu, qu, tu;
        logic [31:0] hs, qs, ts;
        logic [51:0] sum;
        logic [7:0]  owner;
        int          fired;
        vu = clamp_usec(r.val_usec);
        pu = clamp_usec(r.per_usec);
        nu = clamp_usec(r.now_usec);
        fired = 0;
        case (r.op)
            OP_SET: begin
                drop_client(r.client);
                if (q_count >= SLOTS) begin
                    post_evt(KIND_FULL, r.client, 0, 0, 1'b1);
                end else begin
                    sum = r.rel ? time_sum(r.now_sec, nu, r.val_sec, vu) : {r.val_sec, vu};
                    place_timer(sum[51:20], sum[19:0], r.per_sec, pu, r.client);
                    post_evt(KIND_SET_DONE, r.client, 0, 0, 1'b1);
                end
            end
            OP_CANCEL: begin
                drop_client(r.client);
                post_evt(KIND_CANCEL_DONE, r.client, 0, 0, 1'b1);
            end
            OP_GET: begin
                forever begin
                    if (q_count == 0) begin
                        post_evt(KIND_EMPTY, r.client, 0, 0, 1'b1);
                        return;
                    end
                    hs = q_exp_sec[0];
                    hu = q_exp_usec[0];
                    if (earlier(r.now_sec, nu, hs, hu)) begin
                        ts = hs - r.now_sec;
                        if (hu >= nu) begin
                            tu = hu - nu;
                        end else begin
                            tu = hu + 20'd1000000 - nu;
                            ts = ts - 32'd1;
                        end
                        post_evt(KIND_TIMEOUT, r.client, ts, tu, 1'b1);
                        return;
                    end
                    if (fired >= EXPIRE_CAP) begin
                        post_evt(KIND_TIMEOUT, r.client, 0, 0, 1'b1);
                        return;
                    end
                    owner = q_owner[0];
                    qs = q_per_sec[0];
                    qu = q_per_usec[0];
                    drop_slot(0);
                    if (qs != 0 || qu != 0) begin
                        sum = time_sum(qs, qu, hs, hu);
                        place_timer(sum[51:20], sum[19:0], qs, qu, owner);
                    end
                    post_evt(KIND_EXPIRED, owner, 0, 0, 1'b0);
                    fired++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_req(logic [1:0] op, logic [7:0] c, logic [31:0] vs,
                           logic [19:0] vu, logic [31:0] ps, logic [19:0] pu,
                           logic rel, logic [31:0] ns, logic [19:0] nu);
        timer_req_t r;
        r.op = op;
        r.client = c;
        r.val_sec = vs;
        r.val_usec = vu;
        r.per_sec = ps;
        r.per_usec = pu;
        r.rel = rel;
        r.now_sec = ns;
        r.now_usec = nu;
        req_q.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        logic nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            nxt = start;
            if (start && !busy) begin
                predict_timer_req(cur_req);
                nxt = 1'b0;
            end
            if (!nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    i_operation     <= cur_req.op;
                    i_client_id     <= cur_req.client;
                    i_value_sec     <= cur_req.val_sec;
                    i_value_usec    <= cur_req.val_usec;
                    i_period_sec    <= cur_req.per_sec;
                    i_period_usec   <= cur_req.per_usec;
                    i_relative_flag <= cur_req.rel;
                    i_now_sec       <= cur_req.now_sec;
                    i_now_usec      <= cur_req.now_usec;
                    nxt = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
            start <= nxt;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        timer_evt_t e;
        if (i_rst_n && o_result_valid) begin
            if (expected_evts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d client %0d", o_result_kind,
                             o_result_client);
            end else begin
                e = expected_evts.pop_front();
                if (o_result_kind !== e.kind || o_result_client !== e.client ||
                    o_time_sec !== e.t_sec || o_time_usec !== e.t_usec ||
                    o_any_pending !== e.pending || o_last_of_run !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp k%0d c%0d t%0d.%0d p%0d l%0d got k%0d c%0d t%0d.%0d p%0d l%0d",
                                 e.kind, e.client, e.t_sec, e.t_usec, e.pending, e.last,
                                 o_result_kind, o_result_client, o_time_sec, o_time_usec,
                                 o_any_pending, o_last_of_run);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] cur_s, ns;
        logic [19:0] cur_u, nu;
        logic [1:0]  op;
        logic [7:0]  c;
        logic [31:0] vs, ps;
        logic [19:0] vu, pu;
        logic        rel;
        int          pick;
        int          acc_u;
        mismatches = 0;
        idle_cycles = 0;
        gap_left = 0;
        burst_left = 4;
        q_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = OP_SET;
        i_client_id = 0;
        i_value_sec = 0;
        i_value_usec = 0;
        i_period_sec = 0;
        i_period_usec = 0;
        i_relative_flag = 0;
        i_now_sec = 0;
        i_now_usec = 0;

        add_req(OP_GET, 8'd0, 0, 0, 0, 0, 0, 0, 0);
        add_req(OP_SET, 8'd1, 32'd5, 0, 0, 0, 0, 0, 0);
        add_req(OP_SET, 8'd2, 32'd5, 0, 0, 0, 0, 0, 0);
        add_req(OP_CANCEL, 8'd3, 0, 0, 0, 0, 0, 0, 0);
        add_req(OP_GET, 8'd255, 0, 0, 0, 0, 0, 32'd4, 20'hFFFFF);
        add_req(OP_GET, 8'd0, 0, 0, 0, 0, 0, 32'd5, 0);
        add_req(2'd3, 8'hAA, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 1,
                32'hFFFFFFFF, 20'hFFFFF);
        add_req(OP_SET, 8'd200, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 1,
                32'd1, 20'hFFFFF);
        add_req(OP_CANCEL, 8'd200, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            add_req(OP_SET, 8'(10 + i), 32'd100 + i, 20'd999999, 0, 0, 0, 0, 0);
        add_req(OP_SET, 8'd10, 0, 20'd1, 0, 20'd1, 0, 0, 0);
        add_req(OP_GET, 8'd7, 0, 0, 0, 0, 0, 32'd1, 0);

        cur_s = 2;
        cur_u = 0;
        for (int n = 0; n < 320; n++) begin
            pick = $urandom_range(0, 99);
            op = (pick < 45) ? OP_SET : (pick < 65) ? OP_CANCEL : (pick < 96) ? OP_GET : 2'd3;
            c = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 19)) : 8'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                rel = 1'b1;
                vs = $urandom_range(0, 3);
                vu = 20'($urandom_range(0, 999999));
            end else if (pick < 8) begin
                rel = 1'($urandom);
                vs = $urandom;
                vu = 20'($urandom);
            end else begin
                rel = 1'b0;
                vs = cur_s + $urandom_range(0, 4);
                vu = 20'($urandom_range(0, 999999));
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                ps = 0;
                pu = 0;
            end else if (pick < 9) begin
                ps = $urandom_range(0, 2);
                pu = 20'($urandom_range(1, 999999));
            end else begin
                ps = $urandom;
                pu = 20'($urandom);
            end
            if ($urandom_range(0, 2) == 0) begin
                acc_u = int'(cur_u) + int'($urandom_range(0, 900000));
                if (acc_u > 999999) begin
                    acc_u = acc_u - 1000000;
                    cur_s = cur_s + 32'd1;
                end
                cur_u = 20'(acc_u);
                cur_s = cur_s + $urandom_range(0, 1);
            end
            ns = cur_s;
            nu = cur_u;
            if ($urandom_range(0, 29) == 0) begin
                ns = $urandom;
                nu = 20'($urandom);
            end
            add_req(op, c, vs, vu, ps, pu, rel, ns, nu);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (req_q.size() == 0 && !start && expected_evts.size() == 0);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_evts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/stq_pkg.sv
rtl/core/stq_cell.sv
rtl/core/sorted_timer_queue.sv
rtl/core/stq_checker.sv
tb/sv/tb_sorted_timer_queue.sv
